FILE: sv/sorted_pair_intersection_core_assert.svh
// Assertion macros shared by the checker of the pair intersection core.
// Depends on a clk and an active-low rst_n in the scope that uses them.
`ifndef SORTED_PAIR_INTERSECTION_CORE_ASSERT_SVH
`define SORTED_PAIR_INTERSECTION_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define SPI_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("spi assertion failed");

// Next-cycle implication, checked out of reset.
`define SPI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("spi assertion failed");

`endif

FILE: sv/spi_pkg.sv
// Shared types and sizes for the sorted pair intersection core.
// No dependencies; every file that uses it refers to it by scoped names.
package spi_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int VERTEX_BITS = 32;
  localparam int PORT_VTX_W  = 32;
  localparam int COUNT_W     = 20;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int CMDQ_DEPTH  = 2;
  localparam int CMDQ_IDX_W  = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CNT_W  = $clog2(CMDQ_DEPTH + 1);

  localparam logic [1:0] ACT_PUSH_LEFT  = 2'd0;
  localparam logic [1:0] ACT_PUSH_RIGHT = 2'd1;
  localparam logic [1:0] ACT_FINISH     = 2'd2;

  typedef enum logic [1:0] {
    CMD_LEFT   = 2'd0,
    CMD_RIGHT  = 2'd1,
    CMD_FINISH = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t              kind;
    logic [VERTEX_BITS-1:0] src;
    logic [VERTEX_BITS-1:0] dst;
  } cmd_t;

endpackage

FILE: sv/spi_front.sv
// Front stage: accepts input items, decodes the action and trims vertices.
// Depends on spi_pkg; feeds the command queue.
module spi_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   in_action,
  input  logic [spi_pkg::PORT_VTX_W-1:0] in_src_vertex,
  input  logic [spi_pkg::PORT_VTX_W-1:0] in_dst_vertex,
  output logic                         cmd_valid,
  input  logic                         cmd_ready,
  output spi_pkg::cmd_t                cmd
);

  logic          cmd_valid_r, cmd_valid_nxt;
  spi_pkg::cmd_t cmd_r, cmd_nxt;
  logic          accept;

  assign in_ready  = !cmd_valid_r || cmd_ready;
  assign accept    = in_valid && in_ready;
  assign cmd_valid = cmd_valid_r;
  assign cmd       = cmd_r;

  always_comb begin
    cmd_nxt       = cmd_r;
    cmd_valid_nxt = cmd_valid_r && !cmd_ready;
    if (accept) begin
      cmd_nxt.src = in_src_vertex[spi_pkg::VERTEX_BITS-1:0];
      cmd_nxt.dst = in_dst_vertex[spi_pkg::VERTEX_BITS-1:0];
      case (in_action)
        spi_pkg::ACT_PUSH_LEFT: begin
          cmd_nxt.kind  = spi_pkg::CMD_LEFT;
          cmd_valid_nxt = 1'b1;
        end
        spi_pkg::ACT_PUSH_RIGHT: begin
          cmd_nxt.kind  = spi_pkg::CMD_RIGHT;
          cmd_valid_nxt = 1'b1;
        end
        spi_pkg::ACT_FINISH: begin
          cmd_nxt.kind  = spi_pkg::CMD_FINISH;
          cmd_valid_nxt = 1'b1;
        end
        default: begin
          // unused code: drop the item
          cmd_valid_nxt = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_valid_r <= 1'b0;
    end else begin
      cmd_valid_r <= cmd_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
  end

endmodule

FILE: sv/spi_cmd_fifo.sv
// Short command queue between the front and back stages.
// Depends on spi_pkg for the command type and depth.
module spi_cmd_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  spi_pkg::cmd_t wr_cmd,
  output logic          rd_valid,
  input  logic          rd_ready,
  output spi_pkg::cmd_t rd_cmd
);

  spi_pkg::cmd_t                     mem_r [spi_pkg::CMDQ_DEPTH];
  logic [spi_pkg::CMDQ_IDX_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [spi_pkg::CMDQ_IDX_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [spi_pkg::CMDQ_CNT_W-1:0]    count_r, count_nxt;
  logic                              push, pop;

  localparam logic [spi_pkg::CMDQ_IDX_W-1:0] LAST_IDX =
    spi_pkg::CMDQ_IDX_W'(spi_pkg::CMDQ_DEPTH - 1);

  assign wr_ready = count_r != spi_pkg::CMDQ_CNT_W'(spi_pkg::CMDQ_DEPTH);
  assign rd_valid = count_r != '0;
  assign rd_cmd   = mem_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_IDX) ? '0 : wr_ptr_r + spi_pkg::CMDQ_IDX_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_IDX) ? '0 : rd_ptr_r + spi_pkg::CMDQ_IDX_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + spi_pkg::CMDQ_CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - spi_pkg::CMDQ_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_cmd;
    end
  end

endmodule

FILE: sv/spi_back.sv
// Back stage: holds both pair queues, walks their heads one compare per
// cycle unless a match waits for a busy result slot, keeps the match count
// and overflow flag, and owns the result register. Depends on spi_pkg.
module spi_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic                           cfg_self_pair_mode,
  input  logic                           cmd_valid,
  output logic                           cmd_ready,
  input  spi_pkg::cmd_t                  cmd,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [spi_pkg::PORT_VTX_W-1:0] out_match_src,
  output logic [spi_pkg::PORT_VTX_W-1:0] out_match_dst,
  output logic                           out_is_done,
  output logic [spi_pkg::COUNT_W-1:0]    out_match_total,
  output logic                           out_overflowed
);

  localparam int IDX_W  = spi_pkg::IDX_W;
  localparam int FILL_W = spi_pkg::FILL_W;
  localparam int SUM_W  = IDX_W + 1;
  localparam int VB     = spi_pkg::VERTEX_BITS;
  localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(spi_pkg::QUEUE_DEPTH - 1);
  localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(spi_pkg::QUEUE_DEPTH);
  localparam logic [spi_pkg::COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_WALK = 2'b10
  } state_t;

  typedef struct packed {
    logic [VB-1:0] src;
    logic [VB-1:0] dst;
  } pair_t;

  function automatic logic [IDX_W-1:0] wrap_next(input logic [IDX_W-1:0] idx);
    return (idx == LAST_IDX) ? '0 : idx + IDX_W'(1);
  endfunction

  function automatic logic [IDX_W-1:0] tail_slot(input logic [IDX_W-1:0] head,
                                                 input logic [FILL_W-1:0] fill);
    logic [SUM_W-1:0] sum;
    sum = {1'b0, head} + SUM_W'(fill);
    if (sum >= SUM_W'(spi_pkg::QUEUE_DEPTH)) begin
      sum = sum - SUM_W'(spi_pkg::QUEUE_DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

  pair_t left_mem_r  [spi_pkg::QUEUE_DEPTH];
  pair_t right_mem_r [spi_pkg::QUEUE_DEPTH];

  state_t                      state_r, state_nxt;
  logic [FILL_W-1:0]           left_fill_r, left_fill_nxt;
  logic [FILL_W-1:0]           right_fill_r, right_fill_nxt;
  logic [IDX_W-1:0]            left_head_r, left_head_nxt;
  logic [IDX_W-1:0]            right_head_r, right_head_nxt;
  logic [spi_pkg::COUNT_W-1:0] count_r, count_nxt, count_inc;
  logic                        ovf_r, ovf_nxt;
  logic                        self_mode_r;

  logic                        out_valid_r, out_valid_nxt;
  logic [VB-1:0]               out_src_r, out_src_nxt;
  logic [VB-1:0]               out_dst_r, out_dst_nxt;
  logic                        out_done_r, out_done_nxt;
  logic [spi_pkg::COUNT_W-1:0] out_total_r, out_total_nxt;
  logic                        out_ovf_r, out_ovf_nxt;

  logic                        left_we, right_we;
  logic [IDX_W-1:0]            left_waddr, right_waddr;
  pair_t                       head_l, head_r, cmd_pair;
  logic                        slot_free, heads_equal, left_less;

  assign cfg_ready = 1'b1;
  assign head_l    = left_mem_r[left_head_r];
  assign head_r    = right_mem_r[right_head_r];
  assign cmd_pair  = '{src: cmd.src, dst: cmd.dst};
  assign slot_free = !out_valid_r || out_ready;
  assign heads_equal = head_l == head_r;
  assign left_less = (head_l.src < head_r.src) ||
                     ((head_l.src == head_r.src) && (head_l.dst < head_r.dst));
  assign count_inc = (count_r == COUNT_MAX) ? count_r : count_r + spi_pkg::COUNT_W'(1);
  assign left_waddr  = tail_slot(left_head_r, left_fill_r);
  assign right_waddr = tail_slot(right_head_r, right_fill_r);

  always_comb begin
    state_nxt      = state_r;
    left_fill_nxt  = left_fill_r;
    right_fill_nxt = right_fill_r;
    left_head_nxt  = left_head_r;
    right_head_nxt = right_head_r;
    count_nxt      = count_r;
    ovf_nxt        = ovf_r;
    cmd_ready      = 1'b0;
    left_we        = 1'b0;
    right_we       = 1'b0;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_src_nxt    = out_src_r;
    out_dst_nxt    = out_dst_r;
    out_done_nxt   = out_done_r;
    out_total_nxt  = out_total_r;
    out_ovf_nxt    = out_ovf_r;

    case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          case (cmd.kind)
            spi_pkg::CMD_FINISH: begin
              // report, then clear all but self mode; hold until the result slot frees
              if (slot_free) begin
                cmd_ready      = 1'b1;
                out_valid_nxt  = 1'b1;
                out_src_nxt    = '0;
                out_dst_nxt    = '0;
                out_done_nxt   = 1'b1;
                out_total_nxt  = count_r;
                out_ovf_nxt    = ovf_r;
                left_fill_nxt  = '0;
                right_fill_nxt = '0;
                left_head_nxt  = '0;
                right_head_nxt = '0;
                count_nxt      = '0;
                ovf_nxt        = 1'b0;
              end
            end
            spi_pkg::CMD_LEFT: begin
              cmd_ready = 1'b1;
              state_nxt = ST_WALK;
              if (left_fill_r == FULL_FILL) begin
                ovf_nxt = 1'b1;
              end else begin
                left_we       = 1'b1;
                left_fill_nxt = left_fill_r + FILL_W'(1);
              end
            end
            spi_pkg::CMD_RIGHT: begin
              cmd_ready = 1'b1;
              state_nxt = ST_WALK;
              if (right_fill_r == FULL_FILL) begin
                ovf_nxt = 1'b1;
              end else begin
                right_we       = 1'b1;
                right_fill_nxt = right_fill_r + FILL_W'(1);
              end
            end
            default: begin
              cmd_ready = 1'b1;
            end
          endcase
        end
      end
      ST_WALK: begin
        if (left_fill_r == '0 || right_fill_r == '0) begin
          state_nxt = ST_IDLE;
        end else if (heads_equal) begin
          if (!self_mode_r || (head_l.src == head_l.dst)) begin
            // emit the match; hold the walk while the result slot is busy
            if (slot_free) begin
              left_head_nxt  = wrap_next(left_head_r);
              right_head_nxt = wrap_next(right_head_r);
              left_fill_nxt  = left_fill_r - FILL_W'(1);
              right_fill_nxt = right_fill_r - FILL_W'(1);
              count_nxt      = count_inc;
              out_valid_nxt  = 1'b1;
              out_src_nxt    = head_l.src;
              out_dst_nxt    = head_l.dst;
              out_done_nxt   = 1'b0;
              out_total_nxt  = count_inc;
              out_ovf_nxt    = ovf_r;
              state_nxt      = ST_IDLE;
            end
          end else begin
            // filtered match: pop both silently and keep walking
            left_head_nxt  = wrap_next(left_head_r);
            right_head_nxt = wrap_next(right_head_r);
            left_fill_nxt  = left_fill_r - FILL_W'(1);
            right_fill_nxt = right_fill_r - FILL_W'(1);
          end
        end else if (left_less) begin
          left_head_nxt = wrap_next(left_head_r);
          left_fill_nxt = left_fill_r - FILL_W'(1);
        end else begin
          right_head_nxt = wrap_next(right_head_r);
          right_fill_nxt = right_fill_r - FILL_W'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      left_fill_r  <= '0;
      right_fill_r <= '0;
      left_head_r  <= '0;
      right_head_r <= '0;
      count_r      <= '0;
      ovf_r        <= 1'b0;
      self_mode_r  <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      left_fill_r  <= left_fill_nxt;
      right_fill_r <= right_fill_nxt;
      left_head_r  <= left_head_nxt;
      right_head_r <= right_head_nxt;
      count_r      <= count_nxt;
      ovf_r        <= ovf_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_valid) begin
        self_mode_r <= cfg_self_pair_mode;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_src_r   <= out_src_nxt;
    out_dst_r   <= out_dst_nxt;
    out_done_r  <= out_done_nxt;
    out_total_r <= out_total_nxt;
    out_ovf_r   <= out_ovf_nxt;
    if (left_we) begin
      left_mem_r[left_waddr] <= cmd_pair;
    end
    if (right_we) begin
      right_mem_r[right_waddr] <= cmd_pair;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_match_src   = spi_pkg::PORT_VTX_W'(out_src_r);
  assign out_match_dst   = spi_pkg::PORT_VTX_W'(out_dst_r);
  assign out_is_done     = out_done_r;
  assign out_match_total = out_total_r;
  assign out_overflowed  = out_ovf_r;

endmodule

FILE: sv/sorted_pair_intersection_core.sv
// Sorted pair intersection core. Each item pushes a (source, destination)
// pair onto the left or right queue (16 pairs each) or finishes the run. A
// front stage registers and decodes items into a two-entry command queue, so
// input keeps flowing while the back stage works. The back stage takes a
// push in its idle state and then walks the queue heads with a single
// comparator, dropping heads on each compare, until a match is emitted or a
// queue runs empty. A finish reports the saturating match count and the
// overflow flag, and clears both queues. At most one result comes from each
// item; a result waiting in the output register holds the back stage on its
// next result, and the input stalls once the command queue and the front
// register fill. self_pair_mode is written over the cfg port, which is
// always ready.
// Depends on spi_pkg, spi_front, spi_cmd_fifo and spi_back.
module sorted_pair_intersection_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic                           cfg_self_pair_mode,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     in_action,
  input  logic [spi_pkg::PORT_VTX_W-1:0] in_src_vertex,
  input  logic [spi_pkg::PORT_VTX_W-1:0] in_dst_vertex,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [spi_pkg::PORT_VTX_W-1:0] out_match_src,
  output logic [spi_pkg::PORT_VTX_W-1:0] out_match_dst,
  output logic                           out_is_done,
  output logic [spi_pkg::COUNT_W-1:0]    out_match_total,
  output logic                           out_overflowed
);

  logic          front_valid, front_ready;
  spi_pkg::cmd_t front_cmd;
  logic          back_valid, back_ready;
  spi_pkg::cmd_t back_cmd;

  spi_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_action     (in_action),
    .in_src_vertex (in_src_vertex),
    .in_dst_vertex (in_dst_vertex),
    .cmd_valid     (front_valid),
    .cmd_ready     (front_ready),
    .cmd           (front_cmd)
  );

  spi_cmd_fifo u_cmdq (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (front_valid),
    .wr_ready (front_ready),
    .wr_cmd   (front_cmd),
    .rd_valid (back_valid),
    .rd_ready (back_ready),
    .rd_cmd   (back_cmd)
  );

  spi_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_self_pair_mode (cfg_self_pair_mode),
    .cmd_valid          (back_valid),
    .cmd_ready          (back_ready),
    .cmd                (back_cmd),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_match_src      (out_match_src),
    .out_match_dst      (out_match_dst),
    .out_is_done        (out_is_done),
    .out_match_total    (out_match_total),
    .out_overflowed     (out_overflowed)
  );

endmodule

FILE: sv/spi_checker.sv
// Port-level checks for the sorted pair intersection core, bound to the top.
// Depends on spi_pkg and sorted_pair_intersection_core_assert.svh.
`include "sorted_pair_intersection_core_assert.svh"

module spi_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [spi_pkg::PORT_VTX_W-1:0] out_match_src,
  input logic [spi_pkg::PORT_VTX_W-1:0] out_match_dst,
  input logic                           out_is_done,
  input logic [spi_pkg::COUNT_W-1:0]    out_match_total,
  input logic                           out_overflowed
);

  // a stalled result holds
  `SPI_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_match_src) && $stable(out_match_dst) && $stable(out_is_done) && $stable(out_match_total) && $stable(out_overflowed))

  // a finish report carries no pair
  `SPI_ASSERT_NOW(a_done_zero_pair, out_valid && out_is_done, out_match_src == '0 && out_match_dst == '0)

  // a match always counts itself
  `SPI_ASSERT_NOW(a_match_counted, out_valid && !out_is_done, out_match_total != '0)

endmodule

bind sorted_pair_intersection_core spi_checker u_spi_checker (.*);
